// ===== hdl/lras_pkg.sv =====
// Shared constants, types and codes of the line rasterizer.
package lras_pkg;

    localparam int CANVAS_SIZE = 64;
    localparam int COORD_W     = $clog2(CANVAS_SIZE);
    localparam int WIDTH_W     = COORD_W + 1;
    localparam int INDEX_W     = 2 * COORD_W;
    localparam int COLOR_W     = 32;
    localparam int ERR_W       = COORD_W + 3;
    localparam int PROD_W      = COORD_W + WIDTH_W;
    localparam int CFG_IDX_W   = 1;
    localparam int S_DATA_W    = 4 * COORD_W;
    localparam int M_DATA_W    = 2 * COORD_W + INDEX_W + COLOR_W;

    typedef logic [COORD_W-1:0] t_coord;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CANVAS_WIDTH = 1'b0,
        CFG_BRUSH_COLOR  = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic adv;
    } t_step_ctl;

    typedef struct packed {
        logic last;
    } t_step_sts;

endpackage

// ===== hdl/lras_stepper.sv =====
// Bresenham stepper: line setup, then one pixel and one index update per advance.
module lras_stepper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lras_pkg::t_step_ctl                 i_ctl,
    input  lras_pkg::t_coord                    i_start_x,
    input  lras_pkg::t_coord                    i_start_y,
    input  lras_pkg::t_coord                    i_end_x,
    input  lras_pkg::t_coord                    i_end_y,
    input  logic [lras_pkg::WIDTH_W-1:0]        i_width,
    output lras_pkg::t_coord                    o_x,
    output lras_pkg::t_coord                    o_y,
    output logic [lras_pkg::INDEX_W-1:0]        o_index,
    output lras_pkg::t_step_sts                 o_sts
);
    import lras_pkg::*;

    t_coord               r_x, n_x;
    t_coord               r_y, n_y;
    logic [INDEX_W-1:0]   r_idx, n_idx;
    logic [ERR_W-1:0]     r_err, n_err;
    t_coord               r_major, n_major;
    t_coord               r_minor, n_minor;
    t_coord               r_left, n_left;
    logic                 r_x_neg, n_x_neg;
    logic                 r_y_neg, n_y_neg;
    logic                 r_swap, n_swap;

    // setup terms
    logic                 w_hor, w_ver, w_x_up, w_y_up;
    t_coord               w_dx, w_dy, w_ld_x, w_ld_y, w_ld_major, w_ld_minor;
    logic                 w_ld_x_neg, w_ld_y_neg, w_ld_swap;
    logic [PROD_W-1:0]    w_prod;
    // step terms
    logic                 w_mv_minor, w_mv_x, w_mv_y;
    logic [INDEX_W-1:0]   w_width_ext, w_idx_dx, w_idx_dy;
    logic [ERR_W-1:0]     w_err_sub;

    always_comb begin
        w_x_up = i_end_x > i_start_x;
        w_y_up = i_end_y > i_start_y;
        w_dx   = w_x_up ? i_end_x - i_start_x : i_start_x - i_end_x;
        w_dy   = w_y_up ? i_end_y - i_start_y : i_start_y - i_end_y;
        w_hor  = i_start_y == i_end_y;
        w_ver  = i_start_x == i_end_x;
        // Horizontal and vertical lines run upwards from the smaller end with no minor steps.
        if (w_hor) begin
            w_ld_x     = w_x_up ? i_start_x : i_end_x;
            w_ld_y     = i_start_y;
            w_ld_x_neg = 1'b0;
            w_ld_y_neg = 1'b0;
            w_ld_swap  = 1'b0;
            w_ld_major = w_dx;
            w_ld_minor = '0;
        end else if (w_ver) begin
            w_ld_x     = i_start_x;
            w_ld_y     = w_y_up ? i_start_y : i_end_y;
            w_ld_x_neg = 1'b0;
            w_ld_y_neg = 1'b0;
            w_ld_swap  = 1'b1;
            w_ld_major = w_dy;
            w_ld_minor = '0;
        end else begin
            w_ld_x     = i_start_x;
            w_ld_y     = i_start_y;
            w_ld_x_neg = !w_x_up;
            w_ld_y_neg = !w_y_up;
            w_ld_swap  = w_dy > w_dx;
            w_ld_major = w_ld_swap ? w_dy : w_dx;
            w_ld_minor = w_ld_swap ? w_dx : w_dy;
        end
        w_prod = PROD_W'(w_ld_y) * PROD_W'(i_width);
    end

    always_comb begin
        w_width_ext = r_y_neg ? -INDEX_W'(i_width) : INDEX_W'(i_width);
        w_mv_minor  = !r_err[ERR_W-1];
        w_mv_x      = r_swap ? w_mv_minor : 1'b1;
        w_mv_y      = r_swap ? 1'b1 : w_mv_minor;
        w_idx_dx    = w_mv_x ? (r_x_neg ? '1 : INDEX_W'(1)) : '0;
        w_idx_dy    = w_mv_y ? w_width_ext : '0;
        w_err_sub   = w_mv_minor ? {2'b00, r_major, 1'b0} : '0;

        n_x     = r_x;
        n_y     = r_y;
        n_idx   = r_idx;
        n_err   = r_err;
        n_major = r_major;
        n_minor = r_minor;
        n_left  = r_left;
        n_x_neg = r_x_neg;
        n_y_neg = r_y_neg;
        n_swap  = r_swap;
        if (i_ctl.load) begin
            n_x     = w_ld_x;
            n_y     = w_ld_y;
            n_idx   = w_prod[INDEX_W-1:0] + INDEX_W'(w_ld_x);
            n_err   = {2'b00, w_ld_minor, 1'b0} - {3'b000, w_ld_major};
            n_major = w_ld_major;
            n_minor = w_ld_minor;
            n_left  = w_ld_major;
            n_x_neg = w_ld_x_neg;
            n_y_neg = w_ld_y_neg;
            n_swap  = w_ld_swap;
        end else if (i_ctl.adv) begin
            n_x    = r_x + (w_mv_x ? (r_x_neg ? '1 : COORD_W'(1)) : '0);
            n_y    = r_y + (w_mv_y ? (r_y_neg ? '1 : COORD_W'(1)) : '0);
            n_idx  = r_idx + w_idx_dx + w_idx_dy;
            n_err  = r_err + {2'b00, r_minor, 1'b0} - w_err_sub;
            n_left = r_left - COORD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_idx   <= '0;
            r_err   <= '0;
            r_major <= '0;
            r_minor <= '0;
            r_left  <= '0;
            r_x_neg <= 1'b0;
            r_y_neg <= 1'b0;
            r_swap  <= 1'b0;
        end else begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_idx   <= n_idx;
            r_err   <= n_err;
            r_major <= n_major;
            r_minor <= n_minor;
            r_left  <= n_left;
            r_x_neg <= n_x_neg;
            r_y_neg <= n_y_neg;
            r_swap  <= n_swap;
        end
    end

    assign o_x       = r_x;
    assign o_y       = r_y;
    assign o_index   = r_idx;
    assign o_sts.last = (r_left == '0);

endmodule

// ===== hdl/line_rasterizer_unit.sv =====
// Top level of the line rasterizer: command intake, sequencer, registers and pixel output.
//
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: start_x, start_y, end_x, end_y
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: pixel_x/y, pixel_index, colour; tlast
//  cfg       in   i_cfg_valid/o_cfg_ready        index: register, data: value
//
// After the accepting beat the block is not ready again until the last pixel of the line has
// been stepped: a setup state (the single start-index multiply), then one pixel per cycle
// from the stepper. Stalls on m_axis hold the stepper in place.
// Synchronous active-low reset returns the sequencer to idle, width to 64 and colour to 0.
module line_rasterizer_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18]
    input  logic [lras_pkg::S_DATA_W-1:0]        s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // pixel_x[5:0], pixel_y[11:6], pixel_index[23:12], pixel_color[55:24]
    output logic [lras_pkg::M_DATA_W-1:0]        m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lras_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lras_pkg::COLOR_W-1:0]         i_cfg_data
);
    import lras_pkg::*;

    t_state               r_state, n_state;
    t_coord               r_sx, r_sy, r_ex, r_ey;
    logic [WIDTH_W-1:0]   r_width;
    logic [COLOR_W-1:0]   r_color;
    logic                 r_out_valid, n_out_valid;
    t_coord               r_out_x, r_out_y;
    logic [INDEX_W-1:0]   r_out_idx;
    logic [COLOR_W-1:0]   r_out_color;
    logic                 r_out_last;

    t_step_ctl            w_ctl;
    t_step_sts            w_sts;
    t_coord               w_px, w_py;
    logic [INDEX_W-1:0]   w_pidx;
    logic                 w_in_beat;

    assign w_in_beat = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    lras_stepper u_stepper (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_start_x (r_sx),
        .i_start_y (r_sy),
        .i_end_x   (r_ex),
        .i_end_y   (r_ey),
        .i_width   (r_width),
        .o_x       (w_px),
        .o_y       (w_py),
        .o_index   (w_pidx),
        .o_sts     (w_sts)
    );

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !m_axis_tready;
        w_ctl         = '0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                w_ctl.load = 1'b1;
                n_state    = S_RUN;
            end
            S_RUN: begin
                // A pixel moves into the output register once the previous beat is gone.
                if (!r_out_valid || m_axis_tready) begin
                    w_ctl.adv   = 1'b1;
                    n_out_valid = 1'b1;
                    if (w_sts.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_width     <= WIDTH_W'(CANVAS_SIZE);
            r_color     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_CANVAS_WIDTH: r_width <= i_cfg_data[WIDTH_W-1:0];
                    CFG_BRUSH_COLOR:  r_color <= i_cfg_data;
                    default:          r_color <= r_color;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_sx <= s_axis_tdata[COORD_W-1:0];
            r_sy <= s_axis_tdata[2*COORD_W-1:COORD_W];
            r_ex <= s_axis_tdata[3*COORD_W-1:2*COORD_W];
            r_ey <= s_axis_tdata[4*COORD_W-1:3*COORD_W];
        end
        if (w_ctl.adv) begin
            r_out_x     <= w_px;
            r_out_y     <= w_py;
            r_out_idx   <= w_pidx;
            r_out_color <= r_color;
            r_out_last  <= w_sts.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_color, r_out_idx, r_out_y, r_out_x};
    assign m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    logic [PROD_W-1:0]  w_chk_prod;
    logic [INDEX_W-1:0] w_chk_idx;
    assign w_chk_prod = PROD_W'(r_out_y) * PROD_W'(r_width);
    assign w_chk_idx  = w_chk_prod[INDEX_W-1:0] + INDEX_W'(r_out_x);

    a_setup_follows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> r_state == S_SETUP)
        else $error("command beat not followed by setup");

    a_index_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_idx == w_chk_idx)
        else $error("pixel index out of step with coordinates");

    a_no_adv_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_ctl.adv)
        else $error("stepper advanced while output stalled");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.adv && w_sts.last) |=> r_state == S_IDLE)
        else $error("sequencer still running after last pixel");
`endif

endmodule

// ===== test/line_rasterizer_unit_test.sv =====
// Self-checking testbench for the line rasterizer: line commands in, pixel beats checked.
`timescale 1ns / 1ps

module line_rasterizer_unit_test;
    import lras_pkg::*;

    localparam int RUN_LIMIT  = 400_000;
    localparam int N_SEGMENTS = 9;
    localparam int SEG_LINES  = 9;

    typedef struct packed {
        logic [5:0] end_y;
        logic [5:0] end_x;
        logic [5:0] start_y;
        logic [5:0] start_x;
    } t_line;

    typedef struct packed {
        logic [5:0]  pixel_x;
        logic [5:0]  pixel_y;
        logic [11:0] pixel_index;
        logic [31:0] pixel_color;
        logic        last_pixel;
    } t_pixel;

    // Holds the expected pixel stream and a private copy of the two registers.
    class pixel_scoreboard;
        logic [6:0]  canvas_width;
        logic [31:0] brush_color;
        t_pixel      pixel_q[$];
        int          errors;

        function new();
            canvas_width = 7'd64;
            brush_color  = '0;
            errors       = 0;
        endfunction

        function void set_reg(t_cfg_reg r, logic [31:0] value);
            if (r == CFG_CANVAS_WIDTH)
                canvas_width = value[6:0];
            else
                brush_color = value;
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction

        function void push_pixel(int px, int py, bit last);
            t_pixel p;
            p.pixel_x     = 6'(px);
            p.pixel_y     = 6'(py);
            p.pixel_index = 12'(((py & 63) * int'(canvas_width) + (px & 63)) & 'hFFF);
            p.pixel_color = brush_color;
            p.last_pixel  = last;
            pixel_q.push_back(p);
        endfunction

        // Straight lines run from the smaller coordinate; all others step from the
        // first endpoint with the error term, swapping axes on steep slopes.
        function void note_line(t_line c);
            int  x1, y1, x2, y2, lo, hi, dx, dy, sx, sy;
            int  major, minor, err, px, py, k;
            bit  steep;
            x1 = c.start_x;
            y1 = c.start_y;
            x2 = c.end_x;
            y2 = c.end_y;
            if (y1 == y2) begin
                lo = (x1 < x2) ? x1 : x2;
                hi = (x1 < x2) ? x2 : x1;
                for (k = lo; k <= hi; k++)
                    push_pixel(k, y1, k == hi);
            end else if (x1 == x2) begin
                lo = (y1 < y2) ? y1 : y2;
                hi = (y1 < y2) ? y2 : y1;
                for (k = lo; k <= hi; k++)
                    push_pixel(x1, k, k == hi);
            end else begin
                dx    = (x2 > x1) ? x2 - x1 : x1 - x2;
                dy    = (y2 > y1) ? y2 - y1 : y1 - y2;
                sx    = (x2 > x1) ? 1 : -1;
                sy    = (y2 > y1) ? 1 : -1;
                steep = dy > dx;
                major = steep ? dy : dx;
                minor = steep ? dx : dy;
                err   = 2 * minor - major;
                px    = x1;
                py    = y1;
                for (k = 0; k <= major; k++) begin
                    push_pixel(px, py, k == major);
                    while (err >= 0) begin
                        if (steep)
                            px += sx;
                        else
                            py += sy;
                        err -= 2 * major;
                    end
                    if (steep)
                        py += sy;
                    else
                        px += sx;
                    err += 2 * minor;
                end
            end
        endfunction

        function void mismatch(string field, longint unsigned want, longint unsigned got);
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (pixel_q.size() == 0) begin
                $display("%0t: pixel beat with nothing expected, expected none, actual x=%0d y=%0d",
                         $time, got.pixel_x, got.pixel_y);
                errors++;
                return;
            end
            want = pixel_q.pop_front();
            if (got.pixel_x !== want.pixel_x)
                mismatch("pixel_x", want.pixel_x, got.pixel_x);
            if (got.pixel_y !== want.pixel_y)
                mismatch("pixel_y", want.pixel_y, got.pixel_y);
            if (got.pixel_index !== want.pixel_index)
                mismatch("pixel_index", want.pixel_index, got.pixel_index);
            if (got.pixel_color !== want.pixel_color)
                mismatch("pixel_color", want.pixel_color, got.pixel_color);
            if (got.last_pixel !== want.last_pixel)
                mismatch("last_pixel", want.last_pixel, got.last_pixel);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_DATA_W-1:0]    s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_DATA_W-1:0]    m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [COLOR_W-1:0]     i_cfg_data;

    pixel_scoreboard book = new();
    int unsigned     src_idle_pct  = 0;
    int unsigned     sink_idle_pct = 0;
    int              cycle_count   = 0;

    line_rasterizer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // The clock starts low so that the first rising edge comes after time zero.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            book.check_pixel('{pixel_x:     m_axis_tdata[5:0],
                               pixel_y:     m_axis_tdata[11:6],
                               pixel_index: m_axis_tdata[23:12],
                               pixel_color: m_axis_tdata[55:24],
                               last_pixel:  m_axis_tlast});
    end

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_line(input t_line c);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        book.note_line(c);
    endtask

    // Writes both registers back to back; the spare upper bits of the width beat are junk.
    task automatic configure(input logic [6:0] width, input logic [31:0] color);
        logic [31:0] width_word;
        width_word  = {$urandom} & 32'hFFFF_FF80 | 32'(width);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_CANVAS_WIDTH;
        i_cfg_data  <= width_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.set_reg(CFG_CANVAS_WIDTH, width_word);
        i_cfg_index <= CFG_BRUSH_COLOR;
        i_cfg_data  <= color;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.set_reg(CFG_BRUSH_COLOR, color);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int    directed_pts[22][4] = '{
            '{0, 0, 0, 0},    '{63, 63, 63, 63}, '{0, 0, 63, 0},    '{63, 5, 0, 5},
            '{0, 63, 63, 63}, '{7, 0, 7, 63},    '{7, 63, 7, 0},    '{63, 12, 63, 10},
            '{0, 0, 63, 63},  '{63, 63, 0, 0},   '{0, 63, 63, 0},   '{63, 0, 0, 63},
            '{0, 0, 63, 1},   '{0, 0, 1, 63},    '{10, 10, 20, 14}, '{10, 10, 14, 20},
            '{20, 14, 10, 10}, '{14, 20, 10, 10}, '{10, 20, 14, 10}, '{20, 10, 10, 14},
            '{30, 30, 31, 31}, '{6, 5, 5, 5}
        };
        int    width_plan[N_SEGMENTS] = '{1, 64, 0, 127, 63, 2, 0, 0, 64};
        t_line c;
        int    seg, n, kind, x1, y1, x2, y2, d;
        int    width;
        logic [31:0] color;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_CANVAS_WIDTH;
        i_cfg_data    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 21;
        sink_idle_pct = 56;
        configure(7'd64, $urandom);
        foreach (directed_pts[i]) begin
            c.start_x = 6'(directed_pts[i][0]);
            c.start_y = 6'(directed_pts[i][1]);
            c.end_x   = 6'(directed_pts[i][2]);
            c.end_y   = 6'(directed_pts[i][3]);
            send_line(c);
        end
        drain();

        for (seg = 0; seg < N_SEGMENTS; seg++) begin
            case (seg / 3)
                0: begin
                    src_idle_pct  = 21;
                    sink_idle_pct = 56;
                end
                1: begin
                    src_idle_pct  = 56;
                    sink_idle_pct = 21;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            width = (seg == 6 || seg == 7) ? $urandom_range(62, 3) : width_plan[seg];
            case (seg % 3)
                0:       color = $urandom;
                1:       color = 32'h0000_0000;
                default: color = 32'hFFFF_FFFF;
            endcase
            configure(7'(width), color);

            for (n = 0; n < SEG_LINES; n++) begin
                kind = $urandom_range(9);
                x1   = $urandom_range(63);
                y1   = $urandom_range(63);
                x2   = $urandom_range(63);
                y2   = $urandom_range(63);
                if (kind == 0) begin
                    y2 = y1;
                end else if (kind == 1) begin
                    x2 = x1;
                end else if (kind == 2) begin
                    x2 = x1;
                    y2 = y1;
                end else if (kind == 3 && x1 != x2) begin
                    // Exact diagonal: the error term never goes negative, so every step is also a minor step.
                    d  = (x1 > x2) ? x1 - x2 : x2 - x1;
                    y1 = $urandom_range(63 - d);
                    y2 = y1 + d;
                    if ($urandom_range(1)) begin
                        y1 = y1 + d;
                        y2 = y2 - d;
                    end
                end
                c.start_x = 6'(x1);
                c.start_y = 6'(y1);
                c.end_x   = 6'(x2);
                c.end_y   = 6'(y2);
                send_line(c);
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (book.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lras_pkg.sv
hdl/lras_stepper.sv
hdl/line_rasterizer_unit.sv
test/line_rasterizer_unit_test.sv
